FILE: hw/rtl/msfd_pkg.sv
// ----------------------------------------------------------------------------
// Magnetic sensor frame deframer package
// Shared constants, register indexes and the structures that travel between
// the window stage and the result stage.
// ----------------------------------------------------------------------------
package msfd_pkg;

    // Frame geometry defaults
    localparam int FRAME_LEN_DEFAULT = 23;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_ON_PATTERN = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [7:0]  HEADER_RESET = 8'hDD;
    localparam logic [15:0] ALL_ON_RESET = 16'h00FF;

    // Result status codes
    localparam logic STATUS_VALID    = 1'b0;
    localparam logic STATUS_BAD_CSUM = 1'b1;

    // Saturation limit of the error counter
    localparam logic [7:0] TALLY_MAX = 8'hFF;

    // Frame seen by the window stage in the cycle of a byte transfer
    typedef struct packed {
        logic              hit;       // full window with header at its oldest byte
        logic              csum_ok;   // checksum byte matches the running sum
        logic [15:0]       switch_word;
        logic signed [7:0] left_dev;
        logic signed [7:0] mid_dev;
        logic signed [7:0] right_dev;
    } t_frame;

    // One result item
    typedef struct packed {
        logic              status;
        logic [15:0]       switch_word;
        logic signed [7:0] left_dev;
        logic signed [7:0] mid_dev;
        logic signed [7:0] right_dev;
        logic              magnet_seen;
        logic              all_on;
        logic [7:0]        bad_frame_count;
    } t_result;

endpackage

FILE: hw/rtl/msfd_window.sv
// ----------------------------------------------------------------------------
// Byte window stage
// Keeps a shift line of the last FRAME_LEN bytes, a fill count and a rolling
// sum of the oldest FRAME_LEN-1 bytes, and flags a frame candidate for the
// byte that is transferred in this cycle.
// ----------------------------------------------------------------------------
module msfd_window #(
    parameter int FRAME_LEN = msfd_pkg::FRAME_LEN_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_byte,
    input  logic [7:0]      i_header_value,
    output msfd_pkg::t_frame o_frame
);
    import msfd_pkg::*;

    localparam int FILL_W = $clog2(FRAME_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_LEN);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_LEN - 1);

    logic [7:0]        r_win [FRAME_LEN];
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_sum;
    logic [7:0]        n_sum;
    logic              full_after;

    // The oldest byte leaves the sum and the former newest byte joins it.
    assign n_sum      = r_sum - r_win[0] + r_win[FRAME_LEN-1];
    assign full_after = (r_fill >= FILL_LAST);

    // Frame check on the window as it stands after this byte enters.
    always_comb begin
        o_frame.hit         = i_push && full_after && (r_win[1] == i_header_value);
        o_frame.csum_ok     = (n_sum == i_byte);
        o_frame.switch_word = {r_win[2], r_win[3]};
        o_frame.left_dev    = r_win[4];
        o_frame.mid_dev     = r_win[5];
        o_frame.right_dev   = r_win[6];
    end

    // Shift line, fill count and rolling sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_win[i] <= 8'h00;
            end
            r_fill <= '0;
            r_sum  <= 8'h00;
        end else if (i_push) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[FRAME_LEN-1] <= i_byte;
            r_sum              <= n_sum;
            if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/msfd_result.sv
// ----------------------------------------------------------------------------
// Result stage
// Formats a checked frame into a result item, keeps the saturating error
// counter and holds results in an output register with a skid register.
// ----------------------------------------------------------------------------
module msfd_result (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msfd_pkg::t_frame i_frame,
    input  logic [15:0]      i_all_on_pattern,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output msfd_pkg::t_result o_result,
    output logic             o_full
);
    import msfd_pkg::*;

    logic [7:0] r_tally;
    logic [7:0] n_tally;
    t_result    n_res;
    t_result    r_main;
    t_result    r_skid;
    logic       r_main_valid;
    logic       r_skid_valid;
    logic       out_xfer;

    // Error counter update: clears on a good frame, saturates on bad ones.
    always_comb begin
        if (i_frame.csum_ok) begin
            n_tally = 8'h00;
        end else if (r_tally == TALLY_MAX) begin
            n_tally = TALLY_MAX;
        end else begin
            n_tally = r_tally + 8'h01;
        end
    end

    // Result formatting; payload fields read zero on a checksum mismatch.
    always_comb begin
        n_res = '0;
        n_res.bad_frame_count = n_tally;
        if (i_frame.csum_ok) begin
            n_res.status      = STATUS_VALID;
            n_res.switch_word = i_frame.switch_word;
            n_res.left_dev    = i_frame.left_dev;
            n_res.mid_dev     = i_frame.mid_dev;
            n_res.right_dev   = i_frame.right_dev;
            n_res.magnet_seen = (i_frame.switch_word != 16'h0000);
            n_res.all_on      = (i_frame.switch_word == i_all_on_pattern);
        end else begin
            n_res.status = STATUS_BAD_CSUM;
        end
    end

    assign out_xfer = r_main_valid && !i_out_stall;

    // Error counter register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= 8'h00;
        end else if (i_frame.hit) begin
            r_tally <= n_tally;
        end
    end

    // Output register and skid register. A new result only arrives while the
    // skid register is empty, since the input side stalls when it is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_frame.hit) begin
                if (!r_main_valid || out_xfer) begin
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_xfer) begin
                r_main_valid <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.hit) begin
            if (!r_main_valid || out_xfer) begin
                r_main <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (out_xfer && r_skid_valid) begin
            r_main <= r_skid;
        end
    end

    assign o_out_valid = r_main_valid;
    assign o_result    = r_main;
    assign o_full      = r_skid_valid;

endmodule

FILE: hw/rtl/mag_sensor_frame_deframer.sv
// ----------------------------------------------------------------------------
// Magnetic sensor frame deframer
// Scans a received byte stream for checksummed sensor frames and reports
// each header position as a decoded frame or a checksum error.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle and checks every window
// position of the stream: once FRAME_LEN bytes have arrived, each byte whose
// transfer leaves a header byte at the oldest window position yields exactly
// one result, registered into the output register or, if that stays occupied,
// the skid register. A rolling sum over the window and a byte shift line
// sustain this rate, and the skid register lets a byte be taken while a
// result waits; the input stalls only when both hold results. Configuration
// writes are taken at any time and should be made while no result is pending.
// ----------------------------------------------------------------------------
module mag_sensor_frame_deframer #(
    parameter int FRAME_LEN = msfd_pkg::FRAME_LEN_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Byte input channel
    input  logic                            i_rx_valid,
    output logic                            o_rx_stall,
    input  logic [7:0]                      i_rx_byte,
    // Result channel
    output logic                            o_res_valid,
    input  logic                            i_res_stall,
    output logic                            o_status,
    output logic [15:0]                     o_switch_word,
    output logic signed [7:0]               o_left_dev,
    output logic signed [7:0]               o_mid_dev,
    output logic signed [7:0]               o_right_dev,
    output logic                            o_magnet_seen,
    output logic                            o_all_on,
    output logic [7:0]                      o_bad_frame_count,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [msfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import msfd_pkg::*;

    logic [7:0]  r_header_value;
    logic [15:0] r_all_on_pattern;
    logic        push;
    logic        res_full;
    t_frame      frame;
    t_result     result;

    // Configuration registers; writes outside the register list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_value   <= HEADER_RESET;
            r_all_on_pattern <= ALL_ON_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_HEADER_VALUE) begin
                r_header_value <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_ALL_ON_PATTERN) begin
                r_all_on_pattern <= i_cfg_data;
            end
        end
    end

    // Byte transfer on the input channel.
    assign o_rx_stall = res_full;
    assign push       = i_rx_valid && !res_full;

    msfd_window #(
        .FRAME_LEN (FRAME_LEN)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_byte         (i_rx_byte),
        .i_header_value (r_header_value),
        .o_frame        (frame)
    );

    msfd_result u_result (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_frame          (frame),
        .i_all_on_pattern (r_all_on_pattern),
        .i_out_stall      (i_res_stall),
        .o_out_valid      (o_res_valid),
        .o_result         (result),
        .o_full           (res_full)
    );

    // Result fields.
    assign o_status          = result.status;
    assign o_switch_word     = result.switch_word;
    assign o_left_dev        = result.left_dev;
    assign o_mid_dev         = result.mid_dev;
    assign o_right_dev       = result.right_dev;
    assign o_magnet_seen     = result.magnet_seen;
    assign o_all_on          = result.all_on;
    assign o_bad_frame_count = result.bad_frame_count;

endmodule
